// File: rtl/core/sbhl_pkg.sv
package sbhl_pkg;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PASS_MIN,
      ST_PASS_MATCH,
      ST_SRCH_OUT,
      ST_RD_OUT
   } state_type;

   localparam int unsigned MATCH_BITS = 9;
   localparam int unsigned DIST_OUT_BITS = 34;
   localparam int unsigned COUNT_OUT_BITS = 16;

   typedef struct packed {
      op_type      op;
      logic [3:0]  node_row;
      logic [3:0]  node_col;
      logic [1:0]  component;
      logic signed [15:0] sample_value;
      logic [1:0]  sample_class;
      logic        last;
   } req_type;

   typedef struct packed {
      logic                      kind;
      logic [MATCH_BITS-1:0]     match_count;
      logic [DIST_OUT_BITS-1:0]  min_distance_sq;
      logic [1:0]                node_label;
      logic [COUNT_OUT_BITS-1:0] count_one;
      logic [COUNT_OUT_BITS-1:0] count_two;
      logic [COUNT_OUT_BITS-1:0] count_three;
   } rsp_type;

   // request after decode in the front end
   typedef struct packed {
      op_type      op;
      logic [3:0]  node_row;
      logic [3:0]  node_col;
      logic [1:0]  component;
      logic signed [15:0] sample_value;
      logic [1:0]  sample_class;
      logic        last;
      logic        in_grid;
      logic        comp_ok;
   } cmd_type;

endpackage

// File: rtl/core/sbhl_front.sv
module sbhl_front #(
   parameter int unsigned GRID_ROWS = 16,
   parameter int unsigned GRID_COLS = 16,
   parameter int unsigned VECTOR_DIMS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sbhl_pkg::req_type  req_data,
   input  logic               clearing,
   output logic               cmd_valid,
   output sbhl_pkg::cmd_type  cmd,
   input  logic               cmd_pop
);

   sbhl_pkg::cmd_type q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   sbhl_pkg::cmd_type dec;

   // classify the request
   always_comb begin
      dec.op           = req_data.op;
      dec.node_row     = req_data.node_row;
      dec.node_col     = req_data.node_col;
      dec.component    = req_data.component;
      dec.sample_value = req_data.sample_value;
      dec.sample_class = req_data.sample_class;
      dec.last         = req_data.last;
      dec.in_grid      = (32'(req_data.node_row) < GRID_ROWS) &&
                         (32'(req_data.node_col) < GRID_COLS);
      dec.comp_ok      = 32'(req_data.component) < VECTOR_DIMS;
   end

   assign busy      = (cnt_ff == 2'd2) || clearing;
   assign push      = start && !busy;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = cmd_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= dec;
      end
   end

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty queue");
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !cmd_pop) |=> busy) else $error("full queue not busy");

endmodule

// File: rtl/core/sbhl_back.sv
module sbhl_back #(
   parameter int unsigned GRID_ROWS = 16,
   parameter int unsigned GRID_COLS = 16,
   parameter int unsigned VECTOR_DIMS = 4,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  sbhl_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   output logic               clearing,
   output logic               rsp_valid,
   output sbhl_pkg::rsp_type  rsp_data
);

   localparam int unsigned NODES = GRID_ROWS * GRID_COLS;
   localparam int unsigned TOTAL = NODES * VECTOR_DIMS;
   localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int unsigned AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int unsigned KW = (VECTOR_DIMS > 1) ? $clog2(VECTOR_DIMS) : 1;
   localparam int unsigned DB = 32 + KW;
   localparam int unsigned CB = COUNT_BITS;

   sbhl_pkg::state_type state_ff, state_in;

   logic signed [15:0] wmem [TOTAL];
   logic [3*CB-1:0]    cmem [NODES];
   logic signed [15:0] samp_ff [VECTOR_DIMS];

   logic [NW-1:0] clr_ff, clr_in, n_ff, n_in;
   logic [AW-1:0] a_ff, a_in;
   logic [KW-1:0] k_ff, k_in;
   logic          iss_ff, iss_in, first_ff, first_in;
   logic [DB-1:0] best_ff, best_in;
   logic [sbhl_pkg::MATCH_BITS-1:0] match_ff, match_in;
   logic [1:0]    cls_ff, cls_in;

   logic          s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s5_v_in;
   logic [KW-1:0] s1_k_ff, s2_k_ff, s3_k_ff;
   logic [NW-1:0] s1_n_ff, s2_n_ff, s3_n_ff, s4_n_ff, s5_n_ff;
   logic signed [15:0] wrd_ff;
   logic signed [16:0] s2_d_ff;
   logic [31:0]   s3_sq_ff;
   logic [DB-1:0] acc_ff, acc_sum, s4_dist_ff;
   logic signed [33:0] prod;

   logic            w_we, samp_we, c_re, c_we;
   logic [AW-1:0]   w_waddr;
   logic [NW-1:0]   c_raddr, c_waddr, cmd_node;
   logic [3*CB-1:0] cnt_rd_ff, c_wdata;
   logic            rsp_v_ff, rsp_v_in;
   sbhl_pkg::rsp_type rsp_ff, rsp_in;
   logic [63:0]     best64;
   logic [CB-1:0]   c1, c2, c3, cbest;
   logic [1:0]      label;

   assign cmd_node = NW'(32'(cmd.node_row) * GRID_COLS + 32'(cmd.node_col));
   assign w_waddr  = AW'(32'(cmd_node) * VECTOR_DIMS + 32'(cmd.component));
   assign clearing = state_ff == sbhl_pkg::ST_CLEAR;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   assign acc_sum = ((s3_k_ff == '0) ? '0 : acc_ff) + DB'(s3_sq_ff);
   assign prod    = s2_d_ff * s2_d_ff;
   assign best64  = 64'(best_ff);

   assign c1 = cnt_rd_ff[0*CB +: CB];
   assign c2 = cnt_rd_ff[1*CB +: CB];
   assign c3 = cnt_rd_ff[2*CB +: CB];

   // argmax, lowest class wins a tie
   always_comb begin
      cbest = '0;
      label = 2'd0;
      if (c1 > cbest) begin
         cbest = c1;
         label = 2'd1;
      end
      if (c2 > cbest) begin
         cbest = c2;
         label = 2'd2;
      end
      if (c3 > cbest) begin
         label = 2'd3;
      end
   end

   // counter write: clearing sweep or saturating increment
   always_comb begin
      c_we    = clearing || s5_v_ff;
      c_waddr = clearing ? clr_ff : s5_n_ff;
      c_wdata = cnt_rd_ff;
      if (clearing) begin
         c_wdata = '0;
      end else begin
         for (int j = 0; j < 3; j++) begin
            if (32'(cls_ff) == j + 1 && cnt_rd_ff[j*CB +: CB] != {CB{1'b1}}) begin
               c_wdata[j*CB +: CB] = cnt_rd_ff[j*CB +: CB] + CB'(1);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      iss_in   = iss_ff;
      a_in     = a_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      first_in = first_ff;
      best_in  = best_ff;
      match_in = match_ff;
      cls_in   = cls_ff;
      cmd_pop  = 1'b0;
      w_we     = 1'b0;
      samp_we  = 1'b0;
      c_re     = 1'b0;
      c_raddr  = cmd_node;
      s5_v_in  = 1'b0;
      rsp_v_in = 1'b0;
      rsp_in   = '0;

      // advance the weight read stream
      if (iss_ff) begin
         a_in = a_ff + AW'(1);
         if (32'(k_ff) == VECTOR_DIMS - 1) begin
            k_in = '0;
            n_in = n_ff + NW'(1);
         end else begin
            k_in = k_ff + KW'(1);
         end
         if (32'(a_ff) == TOTAL - 1) begin
            iss_in = 1'b0;
         end
      end

      unique case (state_ff)
         sbhl_pkg::ST_CLEAR: begin
            if (32'(clr_ff) == NODES - 1) begin
               state_in = sbhl_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + NW'(1);
            end
         end
         sbhl_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  sbhl_pkg::OP_LOAD: begin
                     w_we = cmd.in_grid && cmd.comp_ok;
                  end
                  sbhl_pkg::OP_SAMPLE: begin
                     samp_we = cmd.comp_ok;
                     if (cmd.last) begin
                        cls_in   = cmd.sample_class;
                        state_in = sbhl_pkg::ST_PASS_MIN;
                        iss_in   = 1'b1;
                        a_in     = '0;
                        k_in     = '0;
                        n_in     = '0;
                        first_in = 1'b1;
                     end
                  end
                  sbhl_pkg::OP_CLEAR: begin
                     state_in = sbhl_pkg::ST_CLEAR;
                     clr_in   = '0;
                  end
                  sbhl_pkg::OP_READ: begin
                     if (cmd.in_grid) begin
                        c_re     = 1'b1;
                        state_in = sbhl_pkg::ST_RD_OUT;
                     end else begin
                        rsp_v_in    = 1'b1;
                        rsp_in.kind = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sbhl_pkg::ST_PASS_MIN: begin
            if (s4_v_ff) begin
               if (first_ff || s4_dist_ff < best_ff) begin
                  best_in = s4_dist_ff;
               end
               first_in = 1'b0;
               if (32'(s4_n_ff) == NODES - 1) begin
                  state_in = sbhl_pkg::ST_PASS_MATCH;
                  iss_in   = 1'b1;
                  a_in     = '0;
                  k_in     = '0;
                  n_in     = '0;
                  match_in = '0;
               end
            end
         end
         sbhl_pkg::ST_PASS_MATCH: begin
            if (s4_v_ff) begin
               if (s4_dist_ff == best_ff) begin
                  if (match_ff != {sbhl_pkg::MATCH_BITS{1'b1}}) begin
                     match_in = match_ff + sbhl_pkg::MATCH_BITS'(1);
                  end
                  if (cls_ff != 2'd0) begin
                     c_re    = 1'b1;
                     c_raddr = s4_n_ff;
                     s5_v_in = 1'b1;
                  end
               end
               if (32'(s4_n_ff) == NODES - 1) begin
                  state_in = sbhl_pkg::ST_SRCH_OUT;
               end
            end
         end
         sbhl_pkg::ST_SRCH_OUT: begin
            rsp_v_in           = 1'b1;
            rsp_in.match_count = match_ff;
            rsp_in.min_distance_sq = (best64 > 64'h3_FFFF_FFFF) ? '1 : best64[33:0];
            state_in           = sbhl_pkg::ST_IDLE;
         end
         sbhl_pkg::ST_RD_OUT: begin
            rsp_v_in           = 1'b1;
            rsp_in.kind        = 1'b1;
            rsp_in.node_label  = label;
            rsp_in.count_one   = 16'(c1);
            rsp_in.count_two   = 16'(c2);
            rsp_in.count_three = 16'(c3);
            state_in           = sbhl_pkg::ST_IDLE;
         end
         default: begin
            state_in = sbhl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbhl_pkg::ST_CLEAR;
         clr_ff   <= '0;
         iss_ff   <= 1'b0;
         first_ff <= 1'b1;
         rsp_v_ff <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         iss_ff   <= iss_in;
         first_ff <= first_in;
         rsp_v_ff <= rsp_v_in;
         s1_v_ff  <= iss_ff;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff && (32'(s3_k_ff) == VECTOR_DIMS - 1);
         s5_v_ff  <= s5_v_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      best_ff    <= best_in;
      match_ff   <= match_in;
      cls_ff     <= cls_in;
      rsp_ff     <= rsp_in;
      s1_k_ff    <= k_ff;
      s1_n_ff    <= n_ff;
      s2_k_ff    <= s1_k_ff;
      s2_n_ff    <= s1_n_ff;
      s2_d_ff    <= {samp_ff[s1_k_ff][15], samp_ff[s1_k_ff]} - {wrd_ff[15], wrd_ff};
      s3_k_ff    <= s2_k_ff;
      s3_n_ff    <= s2_n_ff;
      s3_sq_ff   <= prod[31:0];
      if (s3_v_ff) begin
         acc_ff <= acc_sum;
      end
      s4_dist_ff <= acc_sum;
      s4_n_ff    <= s3_n_ff;
      s5_n_ff    <= s4_n_ff;
      if (samp_we) begin
         samp_ff[KW'(cmd.component)] <= cmd.sample_value;
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= cmd.sample_value;
      end
      wrd_ff <= wmem[a_ff];
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         cmem[c_waddr] <= c_wdata;
      end
      if (c_re) begin
         cnt_rd_ff <= cmem[c_raddr];
      end
   end

   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbhl_pkg::ST_SRCH_OUT) |-> !(s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff))
      else $error("search result before pipeline drained");
   a_no_inc_in_clear: assert property (@(posedge clock) disable iff (reset)
      !(clearing && s5_v_ff)) else $error("increment during clearing sweep");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == sbhl_pkg::ST_IDLE)) else $error("pop outside idle");

endmodule

// File: rtl/core/som_bmu_hit_labeler_core.sv
// Channel   | Ports                         | Handshake
// ----------+-------------------------------+-----------------------------------
// request   | start, busy, req_data         | taken when start high, busy low
// result    | rsp_valid, rsp_data           | one-cycle strobe, cannot be held
//
// A weight load or a sample component without last leaves the queue once the
// back end is idle; a label read reads the counter memory and answers from
// ST_RD_OUT (a node outside the grid is answered straight from idle).
// A search takes two passes over all nodes, one weight component per cycle
// from the single weight memory read port; each pass waits for the pipeline
// to drain before the next state, and the result leaves from ST_SRCH_OUT.
// Clearing the counters, after reset or on request, sweeps one node a cycle;
// busy holds during the sweep.
// A two-entry queue lets requests arrive while a search runs; the result side
// never stalls.
module som_bmu_hit_labeler_core #(
   parameter int unsigned GRID_ROWS = 16,
   parameter int unsigned GRID_COLS = 16,
   parameter int unsigned VECTOR_DIMS = 4,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sbhl_pkg::req_type req_data,
   output logic              rsp_valid,
   output sbhl_pkg::rsp_type rsp_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   logic              clearing;
   sbhl_pkg::cmd_type cmd;

   // front: classify the request and hold it in the queue
   sbhl_front #(
      .GRID_ROWS  (GRID_ROWS),
      .GRID_COLS  (GRID_COLS),
      .VECTOR_DIMS(VECTOR_DIMS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .clearing (clearing),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop)
   );

   // back: execute loads, searches, clears and reads one at a time
   sbhl_back #(
      .GRID_ROWS  (GRID_ROWS),
      .GRID_COLS  (GRID_COLS),
      .VECTOR_DIMS(VECTOR_DIMS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .clearing (clearing),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule
